FILE: hw/rtl/ssgd_pkg.sv
package ssgd_pkg;

  localparam int RAM_BYTES  = 14;
  localparam int GRID_COUNT = 7;
  localparam int RAM_AW     = 4;   // holds RAM indexes up to 15
  localparam int GRID_W     = 3;   // holds grids up to 7
  localparam int SEQ_W      = 5;   // byte counter, up to RAM_BYTES + 2

  // command bytes
  localparam logic [7:0] CMD_WRITE       = 8'h40;
  localparam logic [7:0] CMD_ADDR0       = 8'hC0;
  localparam logic [7:0] CMD_BRIGHT_ON   = 8'h88;
  localparam logic [7:0] CMD_DISP_OFF    = 8'h80;
  localparam logic [7:0] CMD_INIT_BRIGHT = 8'h8F;

  localparam logic [7:0] CODE_DASH      = 8'hFE;
  localparam logic [7:0] DASH_SEGMENTS  = 8'h08;
  localparam logic [7:0] BLANK_SEGMENTS = 8'h00;
  localparam logic [7:0] MASK_MARK      = 8'h02;
  localparam logic [7:0] MASK_POS8      = 8'h01;

  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'h77, 8'h24, 8'h5D, 8'h6D, 8'h2E, 8'h6B, 8'h7B, 8'h25, 8'h7F, 8'h6F
  };

  // register select, paddr[2]
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_ENABLE     = 1'b1;

  typedef enum logic [2:0] {
    OP_SET_DIGIT = 3'd0,
    OP_SET_MARK  = 3'd1,
    OP_FLUSH     = 3'd2,
    OP_BRIGHT    = 3'd3,
    OP_INIT      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] seg_of(input logic [7:0] code);
    logic [7:0] seg;
    if (code <= 8'd9) begin
      seg = DIGIT_SEG[code[3:0]];
    end else if (code == CODE_DASH) begin
      seg = DASH_SEGMENTS;
    end else begin
      seg = BLANK_SEGMENTS;
    end
    return seg;
  endfunction

endpackage

FILE: hw/rtl/seven_segment_grid_display_driver.sv
// Set digit walks GRID_COUNT read/write pairs of the RAM, a seg10 mark one read/write pair;
// brightness 1 byte, flush RAM_BYTES+2 bytes, init RAM_BYTES+3 bytes, one byte per cycle
// while m_tready stays high; the first byte goes from the emit state into the output register.
// One item at a time: no new item is taken until the RAM walk or the byte walk is done.
// Reset (rst, synchronous, active high): RAM reads as zero, brightness 7, display on,
// no output pending. No clearing pass: per-entry valid bits, cleared at once.
module seven_segment_grid_display_driver
  import ssgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] position, [11:4] digit_code,
                                 // [14:12] grid_index, [15] segment_on
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  // serial byte stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] serial_byte
  output logic [1:0]  m_tuser,   // [0] frame_start, [1] frame_end
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // input fields
  logic [3:0] in_position;
  logic [7:0] in_digit_code;
  logic [2:0] in_grid_index;
  logic       in_segment_on;
  op_t        in_op;

  assign in_position   = s_tdata[3:0];
  assign in_digit_code = s_tdata[11:4];
  assign in_grid_index = s_tdata[14:12];
  assign in_segment_on = s_tdata[15];
  assign in_op         = op_t'(s_tuser);

  // control
  state_t state, state_next;
  logic   accept;

  // latched item
  op_t              op;
  logic [GRID_W-1:0] g;        // current grid in the read-modify-write walk
  logic [GRID_W-1:0] g_end;
  logic              odd;      // low/high byte of the grid pair
  logic [7:0]        mask;
  logic [7:0]        setv;     // per grid: set or clear
  logic [SEQ_W-1:0]  seq;      // byte index in the emitted sequence

  // configuration registers
  logic [2:0] brightness_level;
  logic       display_enable;

  // display RAM, one read and one write port, read data registered
  logic [7:0]          ram [RAM_BYTES];
  logic [RAM_BYTES-1:0] ram_valid;
  logic [7:0]          rd_data;
  logic                ram_re, ram_we, clear_all;
  logic [RAM_AW-1:0]   ram_raddr;
  logic [RAM_AW-1:0]   rmw_idx;
  logic                idx_ok;
  logic [7:0]          wdata;

  // output byte
  logic       out_free, out_load;
  logic [7:0] byte_val;
  logic       byte_fs, byte_fe, byte_last;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = (state == ST_IDLE);
  assign rmw_idx  = {g, odd};
  assign idx_ok   = ({1'b0, rmw_idx} < (RAM_AW + 1)'(RAM_BYTES));
  assign wdata    = setv[g] ? (rd_data | mask) : (rd_data & ~mask);
  assign out_free = ~m_tvalid | m_tready;

  // byte generator for the emit walk
  always_comb begin
    byte_val  = rd_data;
    byte_fs   = 1'b0;
    byte_fe   = 1'b0;
    byte_last = 1'b0;
    priority if (op == OP_BRIGHT) begin
      byte_val  = display_enable ? (CMD_BRIGHT_ON | {5'b0, brightness_level}) : CMD_DISP_OFF;
      byte_fs   = 1'b1;
      byte_fe   = 1'b1;
      byte_last = 1'b1;
    end else if (seq == '0) begin
      byte_val = CMD_WRITE;
      byte_fs  = 1'b1;
      byte_fe  = 1'b1;
    end else if (seq == SEQ_W'(1)) begin
      byte_val = CMD_ADDR0;
      byte_fs  = 1'b1;
    end else if (seq == SEQ_W'(RAM_BYTES + 2)) begin
      // init trailer: full brightness, display on
      byte_val  = CMD_INIT_BRIGHT;
      byte_fs   = 1'b1;
      byte_fe   = 1'b1;
      byte_last = 1'b1;
    end else begin
      // RAM byte, prefetched into rd_data while the byte before it is loaded
      byte_fe   = (seq == SEQ_W'(RAM_BYTES + 1));
      byte_last = byte_fe & (op == OP_FLUSH);
    end
  end

  // next state and RAM control
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = rmw_idx;
    clear_all  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_SET_DIGIT: begin
              if (in_position <= 4'd8) state_next = ST_RMW_RD;
            end
            OP_SET_MARK: begin
              if ({1'b0, in_grid_index} < (GRID_W + 1)'(GRID_COUNT)) state_next = ST_RMW_RD;
            end
            OP_FLUSH, OP_BRIGHT: begin
              state_next = ST_EMIT;
            end
            OP_INIT: begin
              clear_all  = 1'b1;
              state_next = ST_EMIT;
            end
            default: state_next = ST_IDLE;  // unused opcodes do nothing
          endcase
        end
      end
      ST_RMW_RD: begin
        ram_re     = 1'b1;
        state_next = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        ram_we     = idx_ok;
        state_next = (g == g_end) ? ST_IDLE : ST_RMW_RD;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (byte_last) begin
            state_next = ST_IDLE;
          end
          // prefetch the next RAM byte: index seq-1
          if (seq >= SEQ_W'(1) && seq <= SEQ_W'(RAM_BYTES) && op != OP_BRIGHT) begin
            ram_re    = 1'b1;
            ram_raddr = RAM_AW'(seq - SEQ_W'(1));
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item latch and walk counters
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= in_op;
      seq <= '0;
      case (in_op)
        OP_SET_DIGIT: begin
          g     <= '0;
          g_end <= GRID_W'(GRID_COUNT - 1);
          odd   <= in_position[3];
          mask  <= in_position[3] ? MASK_POS8 : (8'h01 << in_position[2:0]);
          setv  <= seg_of(in_digit_code);
        end
        OP_SET_MARK: begin
          g     <= in_grid_index;
          g_end <= in_grid_index;
          odd   <= 1'b1;
          mask  <= MASK_MARK;
          setv  <= {8{in_segment_on}};
        end
        default: begin
        end
      endcase
    end else begin
      if (state == ST_RMW_WR && g != g_end) begin
        g <= g + GRID_W'(1);
      end
      if (out_load) begin
        seq <= seq + SEQ_W'(1);
      end
    end
  end

  // display RAM
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram[rmw_idx] <= wdata;
    end
    if (ram_re) begin
      rd_data <= ram_valid[ram_raddr] ? ram[ram_raddr] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      ram_valid <= '0;
    end else if (ram_we) begin
      ram_valid[rmw_idx] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= byte_val;
      m_tuser <= {byte_fe, byte_fs};
      m_tlast <= byte_last;
    end
  end

  // configuration port; write lands on the access cycle
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_level <= 3'd7;
      display_enable   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ENABLE) begin
        display_enable <= pwdata[0];
      end else begin
        brightness_level <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BRIGHTNESS) begin
      prdata = {29'b0, brightness_level};
    end else begin
      prdata = {31'b0, display_enable};
    end
  end

endmodule

FILE: hw/rtl/ssgd_port_chk.sv
module ssgd_port_chk
  import ssgd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output changed while stalled");

  // no new item while a byte sequence is still in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a byte sequence");

  // the final byte of an item always closes a frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("last byte does not end a frame");

  // a flush keeps the input side closed on the following cycle
  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_FLUSH |=> !s_tready)
    else $error("flush did not start the byte walk");

endmodule

bind seven_segment_grid_display_driver ssgd_port_chk u_ssgd_port_chk (.*);

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssgd_pkg::*;

  // Set digit walks the RAM with no output, so a quiet
  // output queue does not yet mean the block is idle.
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;   // long sink hold-off, fills the block
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all
  localparam int IDLE_PCT     = 23;

  // opcodes the block does not decode
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  // byte values on the serial side
  localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
  localparam logic [7:0] BYTE_ADDR_CMD = 8'hC0;
  localparam logic [7:0] BYTE_LIT_BASE = 8'h88;
  localparam logic [7:0] BYTE_DARK     = 8'h80;
  localparam logic [7:0] BYTE_INIT_LIT = 8'h8F;

  localparam logic [7:0] DASH_CODE = 8'hFE;
  localparam logic [7:0] DASH_SEGS = 8'h08;
  localparam logic [7:0] MARK_BIT  = 8'h02;
  localparam logic [7:0] POS8_BIT  = 8'h01;

  // segment patterns for digits 0..9, bit g lights grid g
  localparam logic [7:0] SEG_FONT [10] = '{
    8'h77, 8'h24, 8'h5D, 8'h6D, 8'h2E, 8'h6B, 8'h7B, 8'h25, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] pos;
    logic [7:0] code;
    logic [2:0] grid;
    logic       on;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;     // strobe low before this byte
    logic       fe;     // strobe high after this byte
    logic       last;   // final byte of the item
  } serial_byte_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_MODEL,       // predictor decides
    ROW_TYPED_BYTE,  // one framed byte, value typed in the row
    ROW_TYPED_NONE,  // no bytes at all
    ROW_REG          // register write, not an item
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    item_t      it;
    logic       reg_sel;
    logic [7:0] val;     // typed byte, or register value
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [3:0] position, [11:4] digit_code,
                          // [14:12] grid_index, [15] segment_on
  logic [2:0]  s_tuser;   // [2:0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] serial_byte
  logic [1:0]  m_tuser;   // [0] frame_start, [1] frame_end
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: shadow of the display RAM and the two registers
  logic [7:0]   shadow_ram [RAM_BYTES];
  logic [2:0]   bright_lvl;
  logic         disp_lit;
  serial_byte_t owed_bytes [$];   // bytes still due from the block

  int failures = 0;
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_req  = 1'b0;

  seven_segment_grid_display_driver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
    failures++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic serial_byte_t framed(input logic [7:0] d, input logic fs,
                                          input logic fe, input logic lst);
    framed = {d, fs, fe, lst};
  endfunction

  // indexes past the RAM are dropped silently
  function automatic void ram_update(input int idx, input logic [7:0] mask,
                                     input logic set);
    if (idx < RAM_BYTES) begin
      if (set) shadow_ram[idx] = shadow_ram[idx] | mask;
      else     shadow_ram[idx] = shadow_ram[idx] & ~mask;
    end
  endfunction

  // write command frame, then address command plus the whole RAM in one frame
  function automatic void add_flush(ref serial_byte_t burst [$]);
    burst.push_back(framed(BYTE_DATA_CMD, 1'b1, 1'b1, 1'b0));
    burst.push_back(framed(BYTE_ADDR_CMD, 1'b1, 1'b0, 1'b0));
    for (int i = 0; i < RAM_BYTES; i++)
      burst.push_back(framed(shadow_ram[i], 1'b0, (i == RAM_BYTES - 1), 1'b0));
  endfunction

  function automatic void predict_bytes(input item_t it, ref serial_byte_t burst [$]);
    logic [7:0] segs;
    burst.delete();
    case (it.op)
      OP_SET_DIGIT: begin
        if (it.pos <= 4'd8) begin
          if (it.code <= 8'd9)            segs = SEG_FONT[it.code[3:0]];
          else if (it.code == DASH_CODE)  segs = DASH_SEGS;
          else                            segs = 8'h00;
          // position p<8 is bit p of byte 2g, position 8 is bit 0 of byte 2g+1
          for (int g = 0; g < GRID_COUNT; g++) begin
            if (it.pos < 4'd8) ram_update(2 * g, 8'd1 << it.pos, segs[g]);
            else               ram_update(2 * g + 1, POS8_BIT, segs[g]);
          end
        end
      end
      OP_SET_MARK: begin
        if (int'(it.grid) < GRID_COUNT) ram_update(2 * int'(it.grid) + 1, MARK_BIT, it.on);
      end
      OP_FLUSH: add_flush(burst);
      OP_BRIGHT: begin
        burst.push_back(framed(disp_lit ? (BYTE_LIT_BASE | {5'd0, bright_lvl}) : BYTE_DARK,
                               1'b1, 1'b1, 1'b0));
      end
      OP_INIT: begin
        // init ignores the registers and leaves them alone
        for (int i = 0; i < RAM_BYTES; i++) shadow_ram[i] = 8'h00;
        add_flush(burst);
        burst.push_back(framed(BYTE_INIT_LIT, 1'b1, 1'b1, 1'b0));
      end
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
  endfunction

  // mostly well-formed digit writes and marks with random content, some
  // flushes and brightness commands, a few inits, out-of-range positions,
  // ignored grids and undecoded opcodes
  function automatic item_t pick_item();
    item_t it;
    int    r;
    int    c;
    it.op   = OP_SET_DIGIT;
    it.pos  = 4'($urandom_range(0, 15));
    it.code = 8'($urandom_range(0, 255));
    it.grid = 3'($urandom_range(0, 7));
    it.on   = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it.op = OP_SET_DIGIT;
      if ($urandom_range(0, 9) != 0) it.pos = 4'($urandom_range(0, 8));
      c = $urandom_range(0, 99);
      if (c < 70)      it.code = 8'($urandom_range(0, 9));
      else if (c < 85) it.code = DASH_CODE;
    end else if (r < 60) begin
      it.op = OP_SET_MARK;
    end else if (r < 72) begin
      it.op = OP_FLUSH;
    end else if (r < 84) begin
      it.op = OP_BRIGHT;
    end else if (r < 90) begin
      it.op = OP_INIT;
    end else begin
      it.op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Called at a falling edge, returns at a falling edge with tvalid still up,
  // so back-to-back items keep tvalid high without a glitch.
  task automatic send_item(input item_t it, input row_kind_t kind, input logic [7:0] typed);
    serial_byte_t burst [$];
    while (src_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {it.on, it.grid, it.code, it.pos};
    do @(posedge clk); while (!s_tready);
    // transaction taken at this edge; the predictor still runs for typed rows
    // so the RAM shadow stays current
    predict_bytes(it, burst);
    if (kind == ROW_TYPED_BYTE) begin
      burst.delete();
      burst.push_back(framed(typed, 1'b1, 1'b1, 1'b1));
    end else if (kind == ROW_TYPED_NONE) begin
      burst.delete();
    end
    foreach (burst[i]) owed_bytes.push_back(burst[i]);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    item_t it;
    int    counted;
    counted = 0;
    while (counted < n) begin
      it = pick_item();
      send_item(it, ROW_MODEL, 8'h00);
      counted++;
    end
  endtask

  // stop offering, wait for every owed byte, then let a RAM walk finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (owed_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // setup + access write, then read back; only the register's own bits count
  task automatic reg_write(input logic sel, input logic [31:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_BRIGHTNESS) bright_lvl = val[2:0];
    else                       disp_lit   = val[0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (sel == REG_BRIGHTNESS) begin
      if (rd[2:0] != val[2:0]) report_mismatch("brightness readback", {29'd0, rd[2:0]},
                                               {29'd0, val[2:0]});
    end else begin
      if (rd[0] != val[0]) report_mismatch("enable readback", {31'd0, rd[0]},
                                           {31'd0, val[0]});
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sink: random backpressure, or a counted hold-off on request.
  initial begin : serial_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= !(sink_idle && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : byte_check
    serial_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_bytes.size() == 0) begin
        report_mismatch("byte with nothing owed", {24'd0, m_tdata}, 32'd0);
      end else begin
        want = owed_bytes.pop_front();
        if (m_tdata != want.data)
          report_mismatch("serial_byte", {24'd0, m_tdata}, {24'd0, want.data});
        if (m_tuser[0] != want.fs)
          report_mismatch("frame_start", {31'd0, m_tuser[0]}, {31'd0, want.fs});
        if (m_tuser[1] != want.fe)
          report_mismatch("frame_end", {31'd0, m_tuser[1]}, {31'd0, want.fe});
        if (m_tlast != want.last)
          report_mismatch("last", {31'd0, m_tlast}, {31'd0, want.last});
      end
    end
  end

  // Watchdog: any transaction on either stream or the register port resets it.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) stuck = 0;
      else stuck++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    row_t  plan [26];
    item_t flush_it;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    for (int i = 0; i < RAM_BYTES; i++) shadow_ram[i] = 8'h00;
    bright_lvl = 3'd7;
    disp_lit   = 1'b1;

    // columns: check, {op, position, digit_code, grid, segment_on}, reg, value
    plan = '{
      // reset values: full brightness, display on, empty RAM
      '{ROW_TYPED_BYTE, '{OP_BRIGHT,    4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h8F},
      '{ROW_MODEL,      '{OP_FLUSH,     4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      // digits at both position extremes, a dash, a blank code
      '{ROW_MODEL,      '{OP_SET_DIGIT, 4'd0,  8'd8,  3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      '{ROW_MODEL,      '{OP_SET_DIGIT, 4'd8,  8'hFE, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      '{ROW_MODEL,      '{OP_SET_DIGIT, 4'd3,  8'd9,  3'd7, 1'b1}, REG_BRIGHTNESS, 8'h00},
      '{ROW_MODEL,      '{OP_SET_DIGIT, 4'd7,  8'hFF, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      // position just past eight is dropped
      '{ROW_TYPED_NONE, '{OP_SET_DIGIT, 4'd9,  8'd1,  3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      // marks on the first and last grid; grid seven is dropped
      '{ROW_MODEL,      '{OP_SET_MARK,  4'd0,  8'h00, 3'd0, 1'b1}, REG_BRIGHTNESS, 8'h00},
      '{ROW_MODEL,      '{OP_SET_MARK,  4'd15, 8'hFF, 3'd6, 1'b1}, REG_BRIGHTNESS, 8'h00},
      '{ROW_TYPED_NONE, '{OP_SET_MARK,  4'd0,  8'h00, 3'd7, 1'b1}, REG_BRIGHTNESS, 8'h00},
      // flush with every unused field at all ones
      '{ROW_MODEL,      '{OP_FLUSH,     4'd15, 8'hFF, 3'd7, 1'b1}, REG_BRIGHTNESS, 8'h00},
      '{ROW_MODEL,      '{OP_SET_MARK,  4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      '{ROW_MODEL,      '{OP_SET_DIGIT, 4'd0,  8'hFE, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      // undecoded opcodes do nothing
      '{ROW_TYPED_NONE, '{OP_RSVD_5,    4'd15, 8'hFF, 3'd7, 1'b1}, REG_BRIGHTNESS, 8'h00},
      '{ROW_TYPED_NONE, '{OP_RSVD_6,    4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      '{ROW_TYPED_NONE, '{OP_RSVD_7,    4'd8,  8'hFE, 3'd6, 1'b1}, REG_BRIGHTNESS, 8'h00},
      '{ROW_MODEL,      '{OP_FLUSH,     4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      // lowest brightness and display off
      '{ROW_REG,        '{OP_FLUSH,     4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      '{ROW_TYPED_BYTE, '{OP_BRIGHT,    4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h88},
      '{ROW_REG,        '{OP_FLUSH,     4'd0,  8'h00, 3'd0, 1'b0}, REG_ENABLE,     8'h00},
      '{ROW_TYPED_BYTE, '{OP_BRIGHT,    4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h80},
      // init sends full brightness even with the display off
      '{ROW_MODEL,      '{OP_INIT,      4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00},
      '{ROW_REG,        '{OP_FLUSH,     4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'hFF},
      '{ROW_REG,        '{OP_FLUSH,     4'd0,  8'h00, 3'd0, 1'b0}, REG_ENABLE,     8'hFF},
      '{ROW_TYPED_BYTE, '{OP_BRIGHT,    4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h8F},
      '{ROW_MODEL,      '{OP_FLUSH,     4'd0,  8'h00, 3'd0, 1'b0}, REG_BRIGHTNESS, 8'h00}
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        reg_write(plan[i].reg_sel, {24'd0, plan[i].val});
      end else begin
        send_item(plan[i].it, plan[i].kind, plan[i].val);
      end
    end

    // back-to-back stretch: no idling on either side
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_random(60);
    drain();
    reg_write(REG_BRIGHTNESS, $urandom);
    reg_write(REG_ENABLE, $urandom);
    src_idle  = 1'b1;
    sink_idle = 1'b1;

    // sink holds off while the source keeps offering; a flush first so the
    // block has bytes stuck and must stall its input
    hold_req = 1'b1;
    flush_it = '{OP_FLUSH, 4'd0, 8'h00, 3'd0, 1'b0};
    send_item(flush_it, ROW_MODEL, 8'h00);
    send_random(39);

    // source pauses until every owed byte is out, then new settings
    repeat (3) begin
      drain();
      reg_write(REG_BRIGHTNESS, $urandom);
      reg_write(REG_ENABLE, $urandom);
      send_random(60);
    end

    drain();
    if (failures == 0) $display("== PASS ==");
    else               $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ssgd_pkg.sv
hw/rtl/seven_segment_grid_display_driver.sv
hw/rtl/ssgd_port_chk.sv
test/tb_top.sv
